// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the MVC atom locator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/mvcl_pkg.sv -----
// ---------------------------------------------------------------------------
// MVC atom locator package
// Constants and types shared by the locator modules.
// ---------------------------------------------------------------------------
package mvcl_pkg;

    localparam int          WIN_W       = 64;
    localparam logic [31:0] TAG_WORD    = 32'h6D76_6343;
    localparam int          MIN_REMAIN  = 14;
    localparam int          MIN_TAG_POS = 8;
    localparam int          ATOM_BACK   = 7;
    localparam int          MIN_BYTES   = 4;
    localparam int          SIZE_PAD    = 4;
    localparam logic [7:0]  VERSION_VAL = 8'd1;
    localparam int          LEN_W       = 16;
    localparam int          SUM_W       = 34;
    localparam int          OUT_DATA_W  = 40;

    typedef struct packed {
        logic             too_long;
        logic [LEN_W-1:0] payload_length;
        logic [LEN_W-1:0] payload_offset;
        logic             found;
    } mvcl_result_t;

endpackage

// ----- hdl/mvc_config_atom_locator.sv -----
// ---------------------------------------------------------------------------
// MVC configuration atom locator
// Scans an extradata blob byte by byte and reports where the mvcC record is.
// ---------------------------------------------------------------------------
// channel  | direction | tdata                                     | side
// s_axis   | in        | [7:0] data_byte                           | tlast = last
// m_axis   | out       | [0] found [16:1] offset [32:17] length    | none
//          |           | [33] too_long, [39:34] zero               |
//
// One byte per cycle sustained while the output is not stalled; each item passes
// an input register and then the scan state update into the output register.
// A result is emitted only for the item carrying tlast.
// Reset clears the scan state; the state also returns to reset after each blob.
// A stalled result holds in the output register while one more byte waits in
// the input register.
// ---------------------------------------------------------------------------
module mvc_config_atom_locator
    import mvcl_pkg::*;
#(
    parameter longint unsigned MAX_LEN = 65535
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found, payload_offset,
                                             // payload_length, too_long, pad
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    mvcl_result_t out_result_reg;
    mvcl_result_t step_result;
    logic         advance;
    logic         step_en;

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    mvcl_tracker #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .last      (in_last_reg),
        .result    (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= step_en && in_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (step_en && in_last_reg)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - $bits(mvcl_result_t))'(0), out_result_reg};

`include "assert_macros.svh"

    `ASSERT_NEXT(a_result_loaded, clk, rst_n, step_en && in_last_reg, m_tvalid)
    `ASSERT_NEXT(a_no_spurious, clk, rst_n, !m_tvalid && !(step_en && in_last_reg), !m_tvalid)
    `ASSERT_SAME(a_accept_room, clk, rst_n, in_valid_reg && !advance, !s_tready)

endmodule

// ----- hdl/mvcl_tracker.sv -----
// ---------------------------------------------------------------------------
// MVC atom tracker
// Per-blob scan state and the end-of-blob check, one byte per step.
// ---------------------------------------------------------------------------
module mvcl_tracker
    import mvcl_pkg::*;
#(
    parameter longint unsigned MAX_LEN = 65535,
    parameter int              CNT_W   = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  logic [7:0]   data_byte,
    input  logic         last,
    output mvcl_result_t result
);

    logic [WIN_W-1:0] byte_window_reg, byte_window_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             first_byte_ok_reg, first_byte_ok_next;
    logic             tag_seen_reg, tag_seen_next;
    logic [CNT_W-1:0] tag_position_reg, tag_position_next;
    logic [31:0]      atom_size_reg, atom_size_next;
    logic             version_byte_ok_reg, version_byte_ok_next;
    logic             overflowed_reg, overflowed_next;

    logic [CNT_W:0]   pos_plus1;
    logic [SUM_W-1:0] remain;
    logic [SUM_W-1:0] size_sum;
    logic [CNT_W-1:0] len_full;
    logic             ok_pre;

    always_comb
    begin
        byte_window_next     = byte_window_reg;
        byte_count_next      = byte_count_reg;
        first_byte_ok_next   = first_byte_ok_reg;
        tag_seen_next        = tag_seen_reg;
        tag_position_next    = tag_position_reg;
        atom_size_next       = atom_size_reg;
        version_byte_ok_next = version_byte_ok_reg;
        overflowed_next      = overflowed_reg;
        pos_plus1            = {1'b0, tag_position_reg} + (CNT_W+1)'(1);

        if (!overflowed_reg)
        begin
            if (byte_count_reg >= CNT_W'(MAX_LEN))
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                if (byte_count_reg == '0)
                begin
                    first_byte_ok_next = (data_byte == VERSION_VAL);
                end
                byte_window_next = {byte_window_reg[WIN_W-9:0], data_byte};
                if (!tag_seen_reg && byte_window_next[31:0] == TAG_WORD)
                begin
                    tag_seen_next     = 1'b1;
                    tag_position_next = byte_count_reg;
                    atom_size_next    = byte_window_next[63:32];
                end
                else if (tag_seen_reg && {1'b0, byte_count_reg} == pos_plus1)
                begin
                    version_byte_ok_next = (data_byte == VERSION_VAL);
                end
                byte_count_next = byte_count_reg + CNT_W'(1);
            end
        end
    end

    // end-of-blob check on the updated state
    always_comb
    begin
        remain   = SUM_W'(byte_count_next) - SUM_W'(tag_position_next)
                   + SUM_W'(ATOM_BACK);
        size_sum = SUM_W'(atom_size_next) + SUM_W'(SIZE_PAD);
        len_full = byte_count_next - tag_position_next - CNT_W'(1);
        ok_pre   = !overflowed_next && first_byte_ok_next && tag_seen_next
                   && (byte_count_next > CNT_W'(MIN_BYTES))
                   && (tag_position_next >= CNT_W'(MIN_TAG_POS));

        result.found          = ok_pre && (remain >= SUM_W'(MIN_REMAIN))
                                && (size_sum <= remain) && version_byte_ok_next;
        result.payload_offset = result.found
                                ? LEN_W'(tag_position_next + CNT_W'(1)) : '0;
        result.payload_length = result.found ? LEN_W'(len_full) : '0;
        result.too_long       = overflowed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_window_reg     <= '1;
            byte_count_reg      <= '0;
            first_byte_ok_reg   <= 1'b0;
            tag_seen_reg        <= 1'b0;
            tag_position_reg    <= '0;
            atom_size_reg       <= '0;
            version_byte_ok_reg <= 1'b0;
            overflowed_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            if (last)
            begin
                byte_window_reg     <= '1;
                byte_count_reg      <= '0;
                first_byte_ok_reg   <= 1'b0;
                tag_seen_reg        <= 1'b0;
                tag_position_reg    <= '0;
                atom_size_reg       <= '0;
                version_byte_ok_reg <= 1'b0;
                overflowed_reg      <= 1'b0;
            end
            else
            begin
                byte_window_reg     <= byte_window_next;
                byte_count_reg      <= byte_count_next;
                first_byte_ok_reg   <= first_byte_ok_next;
                tag_seen_reg        <= tag_seen_next;
                tag_position_reg    <= tag_position_next;
                atom_size_reg       <= atom_size_next;
                version_byte_ok_reg <= version_byte_ok_next;
                overflowed_reg      <= overflowed_next;
            end
        end
    end

`include "assert_macros.svh"

    `ASSERT_NEXT(a_clear_after_last, clk, rst_n, step_en && last, byte_count_reg == '0 && !tag_seen_reg && !overflowed_reg)
    `ASSERT_SAME(a_tag_not_early, clk, rst_n, tag_seen_reg, tag_position_reg >= CNT_W'(3))
    `ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, byte_count_reg <= CNT_W'(MAX_LEN))
    `ASSERT_SAME(a_found_excl, clk, rst_n, result.found, !result.too_long)

endmodule

// ----- bench/tb_mvc_config_atom_locator.sv -----
// ---------------------------------------------------------------------------
// Testbench for the MVC configuration atom locator
// Streams extradata blobs into the locator, one byte per item, and checks
// every result against a cycle-free model of the scan kept in a scoreboard.
// Blobs are mostly well-formed mvcC records with random content and sizes
// near the fit boundary, plus flawed records and noise. Source gaps and
// sink stalls vary by phase.
// ---------------------------------------------------------------------------
module tb_mvc_config_atom_locator;
    import mvcl_pkg::*;

    localparam longint unsigned MAX_LEN   = 65535;
    localparam logic [7:0] FIRST_VAL      = 8'd1;
    localparam int         REPORT_LIMIT   = 10;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         STALL_LIMIT    = 4000;
    localparam int         PHASE_ITEMS    = 210;
    localparam int         DRAIN_CYCLES   = 4;

    typedef enum int unsigned {
        FLAW_FIRST_BYTE,
        FLAW_VERSION,
        FLAW_TAG,
        FLAW_EARLY_TAG,
        FLAW_SHORT,
        FLAW_CUT
    } flaw_e;

    class atom_search_model;
        logic [63:0]     window;
        longint unsigned count;
        bit              first_ok;
        bit              tag_seen;
        longint unsigned tag_pos;
        logic [31:0]     atom_size;
        bit              version_ok;
        bit              overflowed;
        mvcl_result_t    pending_reports[$];
        int              failures;

        function new();
            failures = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            window     = '1;
            count      = 0;
            first_ok   = 1'b0;
            tag_seen   = 1'b0;
            tag_pos    = 0;
            atom_size  = '0;
            version_ok = 1'b0;
            overflowed = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b, logic is_last);
            longint unsigned n;
            longint unsigned remain;
            bit              ok;
            mvcl_result_t    rep;
            if (!overflowed)
            begin
                if (count >= MAX_LEN)
                    overflowed = 1'b1;
                else
                begin
                    if (count == 0)
                        first_ok = (b == FIRST_VAL);
                    window = {window[55:0], b};
                    if (!tag_seen && window[31:0] == TAG_WORD)
                    begin
                        tag_seen  = 1'b1;
                        tag_pos   = count;
                        atom_size = window[63:32];
                    end
                    else if (tag_seen && count == tag_pos + 1)
                        version_ok = (b == VERSION_VAL);
                    count = count + 1;
                end
            end
            if (!is_last)
                return;
            n  = count;
            ok = !overflowed && first_ok && n > MIN_BYTES && tag_seen &&
                 tag_pos >= MIN_TAG_POS;
            if (ok)
            begin
                remain = n - tag_pos + ATOM_BACK;
                // 64-bit sum, so an all-ones size does not wrap
                ok = remain >= MIN_REMAIN &&
                     (longint'(atom_size) + SIZE_PAD) <= remain && version_ok;
            end
            rep.found          = ok;
            rep.payload_offset = ok ? LEN_W'(tag_pos + 1) : '0;
            rep.payload_length = ok ? LEN_W'(n - tag_pos - 1) : '0;
            rep.too_long       = overflowed;
            pending_reports.push_back(rep);
            clear_scan();
        endfunction

        function void check_report(logic [OUT_DATA_W-1:0] data);
            mvcl_result_t got;
            mvcl_result_t want;
            got = data[$bits(mvcl_result_t)-1:0];
            if (pending_reports.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result, tdata %h", data);
                return;
            end
            want = pending_reports.pop_front();
            if (got !== want || data[OUT_DATA_W-1:$bits(mvcl_result_t)] !== '0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: exp found=%0d off=%0d len=%0d too_long=%0d | %s",
                             want.found, want.payload_offset, want.payload_length,
                             want.too_long,
                             $sformatf("got found=%0d off=%0d len=%0d too_long=%0d pad=%0h",
                                       got.found, got.payload_offset,
                                       got.payload_length, got.too_long,
                                       data[OUT_DATA_W-1:$bits(mvcl_result_t)]));
            end
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;     // [7:0] data_byte
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [0] found [16:1] offset
                                             // [32:17] length [33] too_long

    atom_search_model scan_model = new();

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_req       = 1'b0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;
    int          items_sent     = 0;
    logic [7:0]  blob_bytes[$];

    mvc_config_atom_locator #(
        .MAX_LEN (MAX_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sink: random stalls, or one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_left <= HOLD_CYCLES;
            hold_req  <= 1'b0;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                scan_model.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                scan_model.check_report(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [7:0] d, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= is_last;
        items_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_blob();
        for (int k = 0; k < blob_bytes.size(); k++)
            send_item(blob_bytes[k], k == blob_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (scan_model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void push_random(int n);
        repeat (n) blob_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void push_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            blob_bytes.push_back(w[8*k +: 8]);
    endfunction

    // tag ends at filler+8; bytes remaining from the size field = tail+9
    function automatic void build_record(int filler, int tail, logic [31:0] size);
        blob_bytes.delete();
        blob_bytes.push_back(FIRST_VAL);
        push_random(filler);
        push_word(size);
        push_word(TAG_WORD);
        blob_bytes.push_back(VERSION_VAL);
        push_random(tail);
    endfunction

    function automatic logic [31:0] pick_size(int tail);
        case ($urandom_range(5))
            0, 1, 2: return 32'(tail + 5 + $urandom_range(3) - 2);
            3:       return '0;
            4:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'hFFFF_FFFC;
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send_random_blob();
        int          shape;
        int          filler;
        int          tail;
        int          cut;
        int          k;
        logic [31:0] size;
        flaw_e       flaw;
        shape  = $urandom_range(99);
        filler = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 12);
        tail   = $urandom_range(5, 16);
        size   = pick_size(tail);
        if (shape < 55)
            build_record(filler, tail, size);
        else if (shape < 85)
        begin
            flaw = flaw_e'($urandom_range(FLAW_CUT));
            build_record(filler, tail, size);
            case (flaw)
                FLAW_FIRST_BYTE:
                begin
                    blob_bytes[0] = 8'($urandom_range(255));
                    if (blob_bytes[0] == FIRST_VAL)
                        blob_bytes[0] = '0;
                end
                FLAW_VERSION:
                begin
                    blob_bytes[filler + 9] = 8'($urandom_range(255));
                    if (blob_bytes[filler + 9] == VERSION_VAL)
                        blob_bytes[filler + 9] = 8'hFF;
                end
                FLAW_TAG:
                begin
                    k = filler + 5 + $urandom_range(3);
                    blob_bytes[k] = blob_bytes[k] ^ (8'd1 << $urandom_range(7));
                end
                FLAW_EARLY_TAG:
                begin
                    // first tag at the earliest allowed position; a later good tag must not count
                    build_record(0, tail, size);
                    push_word(size);
                    push_word(TAG_WORD);
                    blob_bytes.push_back(VERSION_VAL);
                    push_random(6);
                end
                FLAW_SHORT:
                    build_record(filler, $urandom_range(4), pick_size($urandom_range(4)));
                FLAW_CUT:
                begin
                    cut = $urandom_range(1, filler + 9);
                    while (blob_bytes.size() > cut)
                        void'(blob_bytes.pop_back());
                end
                default: ;
            endcase
        end
        else
        begin
            blob_bytes.delete();
            blob_bytes.push_back($urandom_range(1) ? FIRST_VAL : 8'($urandom_range(255)));
            push_random($urandom_range(0, 12));
            if ($urandom_range(1))
                push_word(TAG_WORD);
            push_random($urandom_range(0, 10));
        end
        send_blob();
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
        int phase_end;
        src_idle_pct   = idle_pct;
        sink_stall_pct <= stall_pct;
        phase_end      = items_sent + PHASE_ITEMS;
        while (items_sent < phase_end)
            send_random_blob();
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: wrong first byte, tag at index 3, early tag, tightest fit
        blob_bytes = {8'h00};
        send_blob();
        blob_bytes.delete();
        push_word(TAG_WORD);
        send_blob();
        blob_bytes = {FIRST_VAL};
        push_word(TAG_WORD);
        send_blob();
        build_record(1, 5, 32'd10);
        send_blob();
        wait_drained();

        run_phase(0, 0);
        run_phase(80, 0);
        run_phase(0, 80);
        run_phase(29, 29);

        // fill the block while the sink holds off, then pause until drained
        src_idle_pct = 0;
        sink_stall_pct <= 0;
        hold_req <= 1'b1;
        repeat (14)
        begin
            blob_bytes.delete();
            push_random($urandom_range(1, 3));
            send_blob();
        end
        wait_drained();

        repeat (8) @(posedge clk);
        if (scan_model.failures == 0 && scan_model.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/mvcl_pkg.sv
hdl/mvcl_tracker.sv
hdl/mvc_config_atom_locator.sv
bench/tb_mvc_config_atom_locator.sv
